// File: rtl/hc_pkg.sv
// humidity compensation package: beat types, coefficient set, register indexes
// and the fixed constants of the compensation chain
// no dependencies
package hc_pkg;

	localparam int NUM_STAGES = 11;

	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_H1 = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_H2 = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_H3 = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_H4 = 8'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_H5 = 8'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_H6 = 8'd5;

	localparam logic signed [20:0] TEMP_BASE  = 21'sd76800;
	localparam logic [31:0]        ROUND_A    = 32'd16384;
	localparam logic signed [19:0] H3_BIAS    = 20'sd32768;
	localparam logic [31:0]        GAIN_BIAS  = 32'd2097152;
	localparam logic [31:0]        ROUND_B    = 32'd8192;
	localparam logic [31:0]        RESULT_MAX = 32'd419430400;

	typedef struct packed {
		logic [15:0]        raw_humidity;
		logic signed [19:0] fine_temperature;
	} hc_in_t;

	typedef struct packed {
		logic [16:0] humidity_q10;
		logic [6:0]  humidity_percent;
	} hc_out_t;

	typedef struct packed {
		logic [7:0]         h1;
		logic signed [15:0] h2;
		logic [7:0]         h3;
		logic signed [15:0] h4;
		logic signed [15:0] h5;
		logic signed [7:0]  h6;
	} hc_coef_t;

endpackage

// File: rtl/hc_cfg_regs.sv
// calibration coefficient registers with their reset values
// depends on hc_pkg
module hc_cfg_regs import hc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output hc_coef_t               coef
);

	hc_coef_t coef_q;

	assign cfg_ready = 1'b1;
	assign coef      = coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.h1 <= 8'd0;
			coef_q.h2 <= 16'sd379;
			coef_q.h3 <= 8'd0;
			coef_q.h4 <= 16'sd281;
			coef_q.h5 <= 16'sd50;
			coef_q.h6 <= 8'sd30;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_H1: coef_q.h1 <= cfg_data[7:0];
				REG_H2: coef_q.h2 <= cfg_data;
				REG_H3: coef_q.h3 <= cfg_data[7:0];
				REG_H4: coef_q.h4 <= cfg_data;
				REG_H5: coef_q.h5 <= cfg_data;
				REG_H6: coef_q.h6 <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/hc_pipe_ctrl.sv
// valid bits and per-stage load enables of the compensation pipeline
// depends on hc_pkg
module hc_pipe_ctrl import hc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [NUM_STAGES-1:0] stage_en
);

	logic [NUM_STAGES-1:0] vld_q;

	// a stage loads when it is empty or its contents move on
	always_comb begin
		stage_en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || result_ready;
		for (int i = NUM_STAGES - 2; i >= 0; i--) begin
			stage_en[i] = !vld_q[i] || stage_en[i+1];
		end
	end

	assign sample_ready = stage_en[0];
	assign result_valid = vld_q[NUM_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (stage_en[0]) begin
				vld_q[0] <= sample_valid;
			end
			for (int i = 1; i < NUM_STAGES; i++) begin
				if (stage_en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

endmodule

// File: rtl/hc_datapath.sv
// eleven-stage arithmetic chain of the humidity compensation
// depends on hc_pkg; enables come from hc_pipe_ctrl
module hc_datapath import hc_pkg::*; (
	input  logic                  clk,
	input  logic [NUM_STAGES-1:0] stage_en,
	input  hc_coef_t              coef,
	input  hc_in_t                sample_data,
	output hc_out_t               result_data
);

	logic [15:0]        raw_s1, raw_s2;
	logic signed [20:0] dev_s1;
	logic [31:0]        p5_s2;
	logic signed [28:0] p6_s2;
	logic signed [29:0] p3_s2;
	logic signed [16:0] lin_s3, lin_s4, lin_s5, lin_s6, lin_s7;
	logic signed [18:0] lt_s3;
	logic signed [19:0] qt_s3;
	logic [31:0]        m_s4;
	logic [31:0]        tg_s5;
	logic [31:0]        pg_s6;
	logic signed [17:0] gain_s7;
	logic [31:0]        v_s8, v_s9, v_s10;
	logic [31:0]        qq_s9;
	logic [31:0]        qh_s10;
	hc_out_t            res_s11;

	logic signed [20:0] dev_c;
	logic signed [36:0] p5_c;
	logic signed [28:0] p6_c;
	logic signed [29:0] p3_c;
	logic [31:0]        lin_c;
	logic signed [38:0] m_c;
	logic [31:0]        pg_c;
	logic [31:0]        gsum_c;
	logic signed [34:0] v_c;
	logic signed [16:0] qv_c;
	logic signed [33:0] qq_c;
	logic signed [24:0] q1_c;
	logic signed [33:0] qh_c;
	logic [31:0]        v2_c;
	logic [31:0]        clamp_c;
	logic [19:0]        res_c;

	always_comb begin
		dev_c  = $signed({sample_data.fine_temperature[19], sample_data.fine_temperature})
			- TEMP_BASE;
		p5_c   = $signed(dev_s1) * $signed(coef.h5);
		p6_c   = $signed(dev_s1) * $signed(coef.h6);
		p3_c   = $signed(dev_s1) * $signed({1'b0, coef.h3});
		lin_c  = {2'b00, raw_s2, 14'd0} - {coef.h4[11:0], 20'd0} - p5_s2 + ROUND_A;
		m_c    = lt_s3 * qt_s3;
		pg_c   = tg_s5 * {{16{coef.h2[15]}}, coef.h2};
		gsum_c = pg_s6 + ROUND_B;
		v_c    = lin_s7 * gain_s7;
		qv_c   = $signed(v_s8[31:15]);
		qq_c   = qv_c * qv_c;
		q1_c   = $signed(qq_s9[31:7]);
		qh_c   = q1_c * $signed({1'b0, coef.h1});
		v2_c   = v_s10 - {{4{qh_s10[31]}}, qh_s10[31:4]};
		priority if (v2_c[31]) begin
			clamp_c = '0;
		end else if (v2_c > RESULT_MAX) begin
			clamp_c = RESULT_MAX;
		end else begin
			clamp_c = v2_c;
		end
		res_c = clamp_c[31:12];
	end

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			raw_s1 <= sample_data.raw_humidity;
			dev_s1 <= dev_c;
		end
		if (stage_en[1]) begin
			raw_s2 <= raw_s1;
			p5_s2  <= p5_c[31:0];
			p6_s2  <= p6_c;
			p3_s2  <= p3_c;
		end
		if (stage_en[2]) begin
			lin_s3 <= $signed(lin_c[31:15]);
			lt_s3  <= p6_s2[28:10];
			qt_s3  <= $signed({p3_s2[29], p3_s2[29:11]}) + H3_BIAS;
		end
		if (stage_en[3]) begin
			lin_s4 <= lin_s3;
			m_s4   <= m_c[31:0];
		end
		if (stage_en[4]) begin
			lin_s5 <= lin_s4;
			tg_s5  <= {{10{m_s4[31]}}, m_s4[31:10]} + GAIN_BIAS;
		end
		if (stage_en[5]) begin
			lin_s6 <= lin_s5;
			pg_s6  <= pg_c;
		end
		if (stage_en[6]) begin
			lin_s7  <= lin_s6;
			gain_s7 <= $signed(gsum_c[31:14]);
		end
		if (stage_en[7]) begin
			v_s8 <= v_c[31:0];
		end
		if (stage_en[8]) begin
			v_s9  <= v_s8;
			qq_s9 <= qq_c[31:0];
		end
		if (stage_en[9]) begin
			v_s10  <= v_s9;
			qh_s10 <= qh_c[31:0];
		end
		if (stage_en[10]) begin
			res_s11.humidity_q10     <= res_c[16:0];
			res_s11.humidity_percent <= res_c[16:10];
		end
	end

	assign result_data = res_s11;

endmodule

// File: rtl/humidity_compensation_core.sv
// humidity compensation core: top level joining registers, pipeline control and datapath
// depends on hc_pkg, hc_cfg_regs, hc_pipe_ctrl, hc_datapath
//
// Usage:
//   sample channel (sample_valid/sample_ready/sample_data) takes one beat per raw
//   humidity reading with its fine temperature; result channel
//   (result_valid/result_ready/result_data) returns one beat per sample, in order,
//   with humidity in Q7.10 and as integer percent.
//   cfg channel writes one coefficient per beat: cfg_index picks h1..h6 (0..5),
//   cfg_data carries the value, low bits kept; other indexes are dropped.
//   cfg_ready is always high. Write coefficients only while no sample is in flight.
// Timing:
//   11 register stages, s1 to s11. One sample per cycle is accepted when the result
//   side keeps up.
// Reset:
//   arst_n clears all valid bits and loads the default coefficients.
// Stall:
//   a low result_ready holds the last stage; earlier stages keep filling empty
//   slots, and sample_ready drops only once every stage holds a sample.
module humidity_compensation_core import hc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_ready,
	input  hc_in_t                 sample_data,
	output logic                   result_valid,
	input  logic                   result_ready,
	output hc_out_t                result_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	hc_coef_t              coef;
	logic [NUM_STAGES-1:0] stage_en;

	hc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	hc_pipe_ctrl u_pipe_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.stage_en     (stage_en)
	);

	hc_datapath u_datapath (
		.clk         (clk),
		.stage_en    (stage_en),
		.coef        (coef),
		.sample_data (sample_data),
		.result_data (result_data)
	);

endmodule
